// ===== sv/tpt_pkg.sv =====
// ---------------------------------------------------------------------------
// tpt_pkg
// Shared types and constants for the TLB / page table translator.
// ---------------------------------------------------------------------------
package tpt_pkg;

  localparam int ADDR_W = 16;
  localparam int CNT_W  = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // input beat taken this cycle
    logic scan_run;    // walk the page table
    logic queue_read;  // fetch the oldest frame FIFO slot
    logic commit;      // apply table, FIFO, TLB and counter updates
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic tlb_hit;         // lookup of the incoming address hit the TLB
    logic scan_done;       // table walk has a result this cycle
    logic scan_found;      // walk matched an entry
    logic found_resident;  // matched entry is resident
  } status_t;

endpackage

// ===== sv/tlb_page_table_translator.sv =====
// ---------------------------------------------------------------------------
// tlb_page_table_translator
// Virtual to physical translation through a TLB backed by a reverse page table.
// ---------------------------------------------------------------------------
//  channel | signals                         | direction
//  --------+---------------------------------+----------
//  in      | in_valid, in_stall, virt_addr   | beat in
//  out     | out_valid, out_stall, phys_addr,| beat out
//          | tlb_hit, page_fault, counts     |
//
// A TLB hit is translated in the accept cycle: one beat per cycle while the output is not stalled.
// A miss walks the page table RAM one entry per cycle through the table RAM's
// single read port, reads the frame FIFO if needed, then commits.
// Reset clears valid bits, pointers and counters; no clearing pass.
// While the output beat is stalled, no new input beat is taken.
// ---------------------------------------------------------------------------
module tlb_page_table_translator #(
  parameter int TLB_ENTRIES   = 16,
  parameter int TABLE_ENTRIES = 256,
  parameter int FRAME_SLOTS   = 256,
  parameter int OFFSET_BITS   = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [tpt_pkg::ADDR_W-1:0] virt_addr,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [tpt_pkg::ADDR_W-1:0] phys_addr,
  output logic                       tlb_hit,
  output logic                       page_fault,
  output logic [tpt_pkg::CNT_W-1:0]  hit_count,
  output logic [tpt_pkg::CNT_W-1:0]  fault_count,
  output logic [tpt_pkg::CNT_W-1:0]  access_count
);

  tpt_pkg::cmd_t    cmd;
  tpt_pkg::status_t status;

  tpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tpt_datapath #(
    .TLB_ENTRIES   (TLB_ENTRIES),
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .FRAME_SLOTS   (FRAME_SLOTS),
    .OFFSET_BITS   (OFFSET_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .virt_addr    (virt_addr),
    .phys_addr    (phys_addr),
    .tlb_hit      (tlb_hit),
    .page_fault   (page_fault),
    .hit_count    (hit_count),
    .fault_count  (fault_count),
    .access_count (access_count)
  );

endmodule

// ===== sv/tpt_ram.sv =====
// ---------------------------------------------------------------------------
// tpt_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module tpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/tpt_ctrl.sv =====
// ---------------------------------------------------------------------------
// tpt_ctrl
// Sequencer: TLB hits finish at accept, misses walk the table, read the frame FIFO if needed, then commit.
// ---------------------------------------------------------------------------
module tpt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  tpt_pkg::status_t status,
  output tpt_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_QREAD  = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_stall = !((state == ST_IDLE) && (!out_valid || !out_stall));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd.accept     = accept;
    cmd.scan_run   = (state == ST_SCAN);
    cmd.queue_read = (state == ST_QREAD);
    cmd.commit     = (state == ST_COMMIT);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && !status.tlb_hit) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          if (status.scan_found && status.found_resident) state_next = ST_COMMIT;
          else state_next = ST_QREAD;
        end
      end
      ST_QREAD:  state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((accept && status.tlb_hit) || cmd.commit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

// ===== sv/tpt_datapath.sv =====
// ---------------------------------------------------------------------------
// tpt_datapath
// TLB, page table walk, frame FIFO, counters and result registers.
// ---------------------------------------------------------------------------
module tpt_datapath #(
  parameter int TLB_ENTRIES   = 16,
  parameter int TABLE_ENTRIES = 256,
  parameter int FRAME_SLOTS   = 256,
  parameter int OFFSET_BITS   = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tpt_pkg::cmd_t                cmd,
  output tpt_pkg::status_t             status,
  input  logic [tpt_pkg::ADDR_W-1:0]   virt_addr,
  output logic [tpt_pkg::ADDR_W-1:0]   phys_addr,
  output logic                         tlb_hit,
  output logic                         page_fault,
  output logic [tpt_pkg::CNT_W-1:0]    hit_count,
  output logic [tpt_pkg::CNT_W-1:0]    fault_count,
  output logic [tpt_pkg::CNT_W-1:0]    access_count
);

  localparam int PW  = tpt_pkg::ADDR_W - OFFSET_BITS;
  localparam int TLW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int TIW = $clog2(TABLE_ENTRIES);
  localparam int QW  = $clog2(FRAME_SLOTS);
  localparam int FW  = $clog2(FRAME_SLOTS + 1);
  localparam logic [TLW-1:0] TLB_LAST   = TLW'(TLB_ENTRIES - 1);
  localparam logic [TIW-1:0] TABLE_LAST = TIW'(TABLE_ENTRIES - 1);
  localparam logic [QW-1:0]  QUEUE_LAST = QW'(FRAME_SLOTS - 1);
  localparam logic [FW-1:0]  QUEUE_FULL = FW'(FRAME_SLOTS);

  function automatic logic [tpt_pkg::ADDR_W-1:0] mk_phys(
    input logic [TIW-1:0] f, input logic [OFFSET_BITS-1:0] o);
    logic [TIW+OFFSET_BITS-1:0] w;
    w = {f, o};
    return tpt_pkg::ADDR_W'(w);
  endfunction

  function automatic logic [tpt_pkg::CNT_W-1:0] sat_inc(
    input logic [tpt_pkg::CNT_W-1:0] v);
    return (v == tpt_pkg::CNT_MAX) ? v : v + 1'b1;
  endfunction

  logic [PW-1:0]          page_in;
  logic [OFFSET_BITS-1:0] off_in;
  assign page_in = virt_addr[tpt_pkg::ADDR_W-1:OFFSET_BITS];
  assign off_in  = virt_addr[OFFSET_BITS-1:0];

  // TLB: tag/frame need no reset, valid bits do
  logic [PW-1:0]          tlb_tag   [TLB_ENTRIES];
  logic [TIW-1:0]         tlb_frame [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_used;
  logic [TLW-1:0]         tlb_fill;

  logic           t_hit;
  logic [TIW-1:0] t_frame;

  // lowest matching entry wins
  always_comb begin
    t_hit   = 1'b0;
    t_frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_used[i] && (tlb_tag[i] == page_in)) begin
        t_hit   = 1'b1;
        t_frame = tlb_frame[i];
      end
    end
  end

  // page table and frame FIFO
  logic [TABLE_ENTRIES-1:0] table_used;
  logic [TABLE_ENTRIES-1:0] table_res;
  logic [TIW-1:0]           table_fill;
  logic [QW-1:0]            qptr;
  logic [FW-1:0]            filled;

  logic [PW-1:0]          page_r;
  logic [OFFSET_BITS-1:0] off_r;
  logic [TIW-1:0]         frame_r;
  logic                   is_new;
  logic                   is_nonres;

  logic [TIW-1:0] rd_idx;
  logic [TIW-1:0] cmp_idx;
  logic           scan_pend;
  logic [PW-1:0]  tbl_rdata;
  logic [TIW-1:0] q_rdata;
  logic           match;
  logic           exhausted;
  logic           q_full;

  logic [tpt_pkg::CNT_W-1:0] hits;
  logic [tpt_pkg::CNT_W-1:0] faults;
  logic [tpt_pkg::CNT_W-1:0] accesses;

  tpt_ram #(.WIDTH(PW), .DEPTH(TABLE_ENTRIES)) u_table_ram (
    .clk     (clk),
    .wr_en   (cmd.commit && is_new),
    .wr_addr (frame_r),
    .wr_data (page_r),
    .rd_en   (cmd.scan_run),
    .rd_addr (rd_idx),
    .rd_data (tbl_rdata)
  );

  tpt_ram #(.WIDTH(TIW), .DEPTH(FRAME_SLOTS)) u_queue_ram (
    .clk     (clk),
    .wr_en   (cmd.commit && (is_new || is_nonres)),
    .wr_addr (qptr),
    .wr_data (frame_r),
    .rd_en   (cmd.queue_read),
    .rd_addr (qptr),
    .rd_data (q_rdata)
  );

  assign match     = scan_pend && table_used[cmp_idx] && (tbl_rdata == page_r);
  assign exhausted = scan_pend && (cmp_idx == TABLE_LAST) && !match;
  assign q_full    = (filled == QUEUE_FULL);

  always_comb begin
    status.tlb_hit        = t_hit;
    status.scan_done      = match || exhausted;
    status.scan_found     = match;
    status.found_resident = table_res[cmp_idx];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tlb_used   <= '0;
      tlb_fill   <= '0;
      table_used <= '0;
      table_res  <= '0;
      table_fill <= '0;
      qptr       <= '0;
      filled     <= '0;
      rd_idx     <= '0;
      scan_pend  <= 1'b0;
      hits       <= '0;
      faults     <= '0;
      accesses   <= '0;
    end else begin
      if (cmd.accept) begin
        rd_idx    <= '0;
        scan_pend <= 1'b0;
        if (t_hit) begin
          hits     <= sat_inc(hits);
          accesses <= sat_inc(accesses);
        end
      end else if (cmd.scan_run) begin
        scan_pend <= 1'b1;
        if (rd_idx != TABLE_LAST) rd_idx <= rd_idx + 1'b1;
      end
      if (cmd.commit) begin
        accesses <= sat_inc(accesses);
        if (is_new || is_nonres) faults <= sat_inc(faults);
        tlb_used[tlb_fill] <= 1'b1;
        tlb_fill <= (tlb_fill == TLB_LAST) ? '0 : tlb_fill + 1'b1;
        if (is_new) begin
          table_used[frame_r] <= 1'b1;
          table_res[frame_r]  <= 1'b1;
          // clear after set: evicting the entry just filled leaves it clear
          if (q_full) table_res[q_rdata] <= 1'b0;
          else filled <= filled + 1'b1;
          qptr       <= (qptr == QUEUE_LAST) ? '0 : qptr + 1'b1;
          table_fill <= (frame_r == TABLE_LAST) ? '0 : frame_r + 1'b1;
        end else if (is_nonres) begin
          table_res[q_rdata] <= 1'b0;
          table_res[frame_r] <= 1'b1;
          qptr <= (qptr == QUEUE_LAST) ? '0 : qptr + 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      page_r <= page_in;
      off_r  <= off_in;
      if (t_hit) begin
        phys_addr  <= mk_phys(t_frame, off_in);
        tlb_hit    <= 1'b1;
        page_fault <= 1'b0;
      end
    end
    if (cmd.scan_run) begin
      cmp_idx <= rd_idx;
      if (match || exhausted) begin
        frame_r   <= match ? cmp_idx : table_fill;
        is_new    <= !match;
        is_nonres <= match && !table_res[cmp_idx];
      end
    end
    if (cmd.commit) begin
      tlb_tag[tlb_fill]   <= page_r;
      tlb_frame[tlb_fill] <= frame_r;
      phys_addr           <= mk_phys(frame_r, off_r);
      tlb_hit             <= 1'b0;
      page_fault          <= is_new || is_nonres;
    end
  end

  assign hit_count    = hits;
  assign fault_count  = faults;
  assign access_count = accesses;

endmodule

// ===== sv/tpt_checker.sv =====
// ---------------------------------------------------------------------------
// tpt_checker
// Port-level checks on the translator's result stream.
// ---------------------------------------------------------------------------
module tpt_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] phys_addr,
  input logic        tlb_hit,
  input logic        page_fault,
  input logic [31:0] hit_count,
  input logic [31:0] fault_count,
  input logic [31:0] access_count
);

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(phys_addr) && $stable(access_count))
    else $error("stalled result changed");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(tlb_hit && page_fault))
    else $error("hit and fault together");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit_count <= access_count) && (fault_count <= access_count))
    else $error("counter exceeds access count");

  a_mono: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall ##1 out_valid && !$past(rst) |-> access_count >= $past(access_count))
    else $error("access count went backward");

endmodule

bind tlb_page_table_translator tpt_checker u_tpt_checker (.*);
